// File: design/msxu_pkg.sv
// Package for the MIPS subset execute unit: opcodes, event and error codes,
// fixed constants. No dependencies.
`default_nettype none
package msxu_pkg;
  localparam logic [31:0] TEXT_BASE = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE = 32'h1000_0000;
  localparam logic [31:0] GP_RESET = 32'h1000_8000;
  localparam logic [31:0] START_RESET = 32'h0040_0000;
  localparam int DATA_BYTES_DEF = 1048576;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J = 6'h02;
  localparam logic [5:0] OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_ANDI = 6'h0c;
  localparam logic [5:0] OP_LUI = 6'h0f;
  localparam logic [5:0] OP_TRAP = 6'h1a;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_SW = 6'h2b;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_JR = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT = 6'h2a;

  localparam logic [3:0] TR_NEWLINE = 4'h0;
  localparam logic [3:0] TR_PRINT = 4'h1;
  localparam logic [3:0] TR_READ = 4'h5;
  localparam logic [3:0] TR_EXIT = 4'ha;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_NEWLINE = 3'd1;
  localparam logic [2:0] EV_PRINT = 3'd2;
  localparam logic [2:0] EV_READ = 3'd3;
  localparam logic [2:0] EV_EXIT = 3'd4;
  localparam logic [2:0] EV_ERROR = 3'd5;

  localparam logic [2:0] ER_NONE = 3'd0;
  localparam logic [2:0] ER_DIVZERO = 3'd1;
  localparam logic [2:0] ER_BADOP = 3'd2;
  localparam logic [2:0] ER_BADTRAP = 3'd3;
  localparam logic [2:0] ER_UNALIGNED = 3'd4;
  localparam logic [2:0] ER_RANGE = 3'd5;
  localparam logic [2:0] ER_FETCH = 3'd6;

  localparam logic [2:0] CFG_START = 3'd0;
  localparam logic [2:0] CFG_WORDS = 3'd1;

  // what the controller asks of the datapath
  typedef struct packed {
    logic load;     // latch instruction and input value
    logic decode;   // first execute step: register reads, simple ops
    logic mdu_go;   // start multiply or divide
    logic mem_rd;   // memory read issued
    logic finish;   // write back, update pc, present result
  } msxu_cmd_t;

  typedef struct packed {
    logic fetch_bad;
    logic is_muldiv;
    logic is_div;
    logic div_zero;
    logic is_load;
    logic mdu_done;
    logic halt_now;
  } msxu_sts_t;
endpackage
`default_nettype wire

// File: design/msxu_mdu.sv
// Iterative signed multiply/divide unit, one bit per cycle.
// Depends on msxu_pkg.
`default_nettype none
module msxu_mdu
  import msxu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      hi_res,
  output logic [31:0]      lo_res
);
  logic        busy;
  logic [5:0]  count;
  logic        div_op;
  logic        neg_q;
  logic        neg_r;
  logic [63:0] acc;
  logic [31:0] opb;
  logic [32:0] trial;
  logic [31:0] abs_a;
  logic [31:0] abs_b;
  logic [63:0] prod_s;
  logic [31:0] quo;
  logic [31:0] rem;

  assign abs_a = a[31] ? 32'(-a) : a;
  assign abs_b = b[31] ? 32'(-b) : b;
  assign trial = {acc[62:31]} - {1'b0, opb};
  assign prod_s = neg_q ? 64'(-acc) : acc;
  assign quo = neg_q ? 32'(-acc[31:0]) : acc[31:0];
  assign rem = neg_r ? 32'(-acc[63:32]) : acc[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        div_op <= is_div;
        neg_q <= a[31] ^ b[31];
        neg_r <= a[31];
        acc <= {32'd0, abs_a};
        opb <= abs_b;
      end else if (busy) begin
        if (count == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (div_op) begin
            hi_res <= rem;
            lo_res <= quo;
          end else begin
            hi_res <= prod_s[63:32];
            lo_res <= prod_s[31:0];
          end
        end else begin
          count <= count + 6'd1;
          if (div_op) begin
            if (!trial[32]) acc <= {trial[31:0], acc[30:0], 1'b1};
            else acc <= {acc[62:0], 1'b0};
          end else begin
            if (acc[0]) acc <= {33'({1'b0, acc[63:32]} + {1'b0, opb}), acc[31:1]};
            else acc <= {1'b0, acc[63:1]};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/msxu_datapath.sv
// Datapath: pc, register file, hi/lo, data memory, ALU, result register.
// Depends on msxu_pkg and msxu_mdu.
`default_nettype none
module msxu_datapath
  import msxu_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire msxu_cmd_t   cmd,
  output msxu_sts_t        sts,
  input  wire logic [31:0] in_instr,
  input  wire logic [31:0] in_value,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic [101:0]     result
);
  localparam int WORDS = DATA_BYTES / 4;
  localparam int AW = $clog2(WORDS);

  logic [31:0] start_address;
  logic [24:0] program_words;
  logic [31:0] pc;
  logic [31:0] regs [32];
  logic [31:0] hi_word;
  logic [31:0] lo_word;
  logic [31:0] mem [WORDS];
  logic [31:0] retired;
  logic [31:0] ins;
  logic [31:0] inval;
  logic [31:0] ra;
  logic [31:0] rb;
  logic [31:0] mem_q;
  logic        mdu_done;
  logic [31:0] mdu_hi;
  logic [31:0] mdu_lo;

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [31:0] uimm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] addr;
  logic [31:0] off;
  logic [31:0] fetch_off;

  // decided in the decode step
  logic        wr_en;
  logic [4:0]  wr_reg;
  logic [31:0] wr_val;
  logic [31:0] npc;
  logic [2:0]  ev;
  logic [2:0]  err;
  logic [31:0] pv;
  logic        st_en;
  logic        ld_en;
  logic [AW-1:0] maddr;
  logic        is_md;
  logic        is_dv;
  logic        dzero;
  logic        fbad;

  logic        c_wr_en;
  logic [4:0]  c_wr_reg;
  logic [31:0] c_wr_val;
  logic [31:0] c_npc;
  logic [2:0]  c_ev;
  logic [2:0]  c_err;
  logic [31:0] c_pv;
  logic        c_st;
  logic        c_ld;

  assign op = ins[31:26];
  assign rs = ins[25:21];
  assign rt = ins[20:16];
  assign rd = ins[15:11];
  assign sh = ins[10:6];
  assign fn = ins[5:0];
  assign uimm = {16'd0, ins[15:0]};
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign pc4 = pc + 32'd4;
  assign ra = regs[rs];
  assign rb = regs[rt];
  assign addr = ra + simm;
  assign off = addr - DATA_BASE;
  assign fetch_off = pc - TEXT_BASE;

  always_comb begin
    c_wr_en = 1'b0;
    c_wr_reg = rd;
    c_wr_val = '0;
    c_npc = pc4;
    c_ev = EV_NONE;
    c_err = ER_NONE;
    c_pv = '0;
    c_st = 1'b0;
    c_ld = 1'b0;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL: begin c_wr_en = 1'b1; c_wr_val = rb << sh; end
          FN_SRA: begin c_wr_en = 1'b1; c_wr_val = $unsigned($signed(rb) >>> sh); end
          FN_JR: c_npc = ra;
          FN_MFHI: begin c_wr_en = 1'b1; c_wr_val = hi_word; end
          FN_MFLO: begin c_wr_en = 1'b1; c_wr_val = lo_word; end
          FN_MULT: ;
          FN_DIV: if (rb == 32'd0) begin c_ev = EV_ERROR; c_err = ER_DIVZERO; end
          FN_ADDU: begin c_wr_en = 1'b1; c_wr_val = ra + rb; end
          FN_SUBU: begin c_wr_en = 1'b1; c_wr_val = ra - rb; end
          FN_SLT: begin
            c_wr_en = 1'b1;
            c_wr_val = {31'd0, $signed(ra) < $signed(rb)};
          end
          default: begin c_ev = EV_ERROR; c_err = ER_BADOP; end
        endcase
      end
      OP_J: c_npc = {pc4[31:28], ins[25:0], 2'b00};
      OP_JAL: begin
        c_wr_en = 1'b1; c_wr_reg = 5'd31; c_wr_val = pc4;
        c_npc = {pc4[31:28], ins[25:0], 2'b00};
      end
      OP_BEQ: if (ra == rb) c_npc = pc4 + {simm[29:0], 2'b00};
      OP_BNE: if (ra != rb) c_npc = pc4 + {simm[29:0], 2'b00};
      OP_ADDIU: begin c_wr_en = 1'b1; c_wr_reg = rt; c_wr_val = ra + simm; end
      OP_ANDI: begin c_wr_en = 1'b1; c_wr_reg = rt; c_wr_val = ra & uimm; end
      OP_LUI: begin c_wr_en = 1'b1; c_wr_reg = rt; c_wr_val = {ins[15:0], 16'd0}; end
      OP_TRAP: begin
        unique case (ins[3:0])
          TR_NEWLINE: c_ev = EV_NEWLINE;
          TR_PRINT: begin c_ev = EV_PRINT; c_pv = ra; end
          TR_READ: begin
            c_ev = EV_READ; c_wr_en = 1'b1; c_wr_reg = rt; c_wr_val = inval;
          end
          TR_EXIT: c_ev = EV_EXIT;
          default: begin c_ev = EV_ERROR; c_err = ER_BADTRAP; end
        endcase
      end
      OP_LW, OP_SW: begin
        if (addr[1:0] != 2'b00) begin
          c_ev = EV_ERROR; c_err = ER_UNALIGNED;
        end else if (off >= 32'(DATA_BYTES)) begin
          c_ev = EV_ERROR; c_err = ER_RANGE;
        end else if (op == OP_LW) begin
          c_ld = 1'b1; c_wr_reg = rt;
        end else begin
          c_st = 1'b1;
        end
      end
      default: begin c_ev = EV_ERROR; c_err = ER_BADOP; end
    endcase
  end

  assign sts.fetch_bad = fbad;
  assign sts.is_muldiv = is_md;
  assign sts.is_div = is_dv;
  assign sts.div_zero = dzero;
  assign sts.is_load = ld_en;
  assign sts.mdu_done = mdu_done;
  assign sts.halt_now = (ev == EV_ERROR) || (ev == EV_EXIT);

  msxu_mdu u_mdu (
    .clk(clk), .rst(rst), .start(cmd.mdu_go), .is_div(is_dv),
    .a(ra), .b(rb), .done(mdu_done), .hi_res(mdu_hi), .lo_res(mdu_lo)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) mem_q <= mem[maddr];
    if (cmd.finish && st_en && !fbad) mem[maddr] <= rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_RESET;
      program_words <= '0;
      pc <= START_RESET;
      hi_word <= '0;
      lo_word <= '0;
      retired <= '0;
      for (int i = 0; i < 32; i++) regs[i] <= '0;
      regs[28] <= GP_RESET;
      regs[29] <= DATA_BASE + 32'(DATA_BYTES);
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_START) begin
          start_address <= cfg_data;
          if (retired == 32'd0) pc <= cfg_data;
        end else if (cfg_index == CFG_WORDS) begin
          program_words <= cfg_data[24:0];
        end
      end
      if (cmd.load) begin
        ins <= in_instr;
        inval <= in_value;
        retired <= retired + 32'd1;
      end
      if (cmd.decode) begin
        fbad <= {2'b00, fetch_off[31:2]} >= {7'd0, program_words};
        wr_en <= c_wr_en;
        wr_reg <= c_wr_reg;
        wr_val <= c_wr_val;
        npc <= c_npc;
        ev <= c_ev;
        err <= c_err;
        pv <= c_pv;
        st_en <= c_st;
        ld_en <= c_ld;
        maddr <= off[AW+1:2];
        is_md <= (op == OP_SPECIAL) && ((fn == FN_MULT) || (fn == FN_DIV));
        is_dv <= (op == OP_SPECIAL) && (fn == FN_DIV);
        dzero <= rb == 32'd0;
      end
      if (mdu_done && !fbad) begin
        if (is_dv && ins[25:21] != 5'd0 && regs[rs] == 32'h8000_0000 && rb == 32'hffff_ffff)
          begin hi_word <= '0; lo_word <= 32'h8000_0000; end
        else begin hi_word <= mdu_hi; lo_word <= mdu_lo; end
      end
      if (cmd.finish) begin
        if (fbad) begin
          result <= {retired, ER_FETCH, 32'd0, EV_ERROR, pc};
        end else begin
          pc <= npc;
          if (wr_reg != 5'd0 && (wr_en || ld_en)) regs[wr_reg] <= ld_en ? mem_q : wr_val;
          result <= {retired, err, pv, ev, npc};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/msxu_ctrl.sv
// Controller state machine: sequences load, decode, multiply/divide, memory
// read and result. Depends on msxu_pkg.
`default_nettype none
module msxu_ctrl
  import msxu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire msxu_sts_t sts,
  output msxu_cmd_t      cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_EXEC, S_MDU, S_MEM, S_FIN, S_OUT} state_t;
  state_t state;
  logic   halted;

  assign in_ready = (state == S_IDLE) && !halted;
  assign cmd.load = in_valid && in_ready;
  assign cmd.decode = state == S_DEC;
  assign cmd.mdu_go = (state == S_EXEC) && !sts.fetch_bad && sts.is_muldiv &&
                      !(sts.is_div && sts.div_zero);
  assign cmd.mem_rd = (state == S_EXEC);
  assign cmd.finish = state == S_FIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      halted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd.load) state <= S_DEC;
        S_DEC: state <= S_EXEC;
        S_EXEC: state <= cmd.mdu_go ? S_MDU : S_FIN;
        S_MDU: if (sts.mdu_done) state <= S_FIN;
        S_MEM: state <= S_FIN;
        S_FIN: begin
          if (sts.fetch_bad || sts.halt_now) halted <= 1'b1;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/mips_subset_execute_unit_core.sv
// Top level of the MIPS subset execute unit. Depends on msxu_pkg,
// msxu_ctrl and msxu_datapath.
//
// One instruction beat in, one result beat out, one instruction in flight.
// The controller steps decode, execute and finish before a result beat is
// valid; the next input beat can be taken in the cycle after the result beat
// is taken. mult and div (not a div by zero or a fetch error) also run a
// one-bit-per-cycle unit in a multiply/divide state. Once an exit or an error
// result is given the unit takes no more beats until reset. Data memory is an
// on-chip array of DATA_BYTES/4 words read in the execute state, the cycle after
// decode.
`default_nettype none
module mips_subset_execute_unit_core
  import msxu_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,  // instr_word, input_value
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // next_pc, print_value, executed_count
  output logic [5:0]        m_axis_tuser,  // event_res, error_code
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  msxu_cmd_t    cmd;
  msxu_sts_t    sts;
  logic [101:0] result;

  assign cfg_ready = 1'b1;

  msxu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts(sts), .cmd(cmd)
  );

  msxu_datapath #(.DATA_BYTES(DATA_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_instr(s_axis_tdata[31:0]), .in_value(s_axis_tdata[63:32]),
    .cfg_we(cfg_valid), .cfg_index({2'b00, cfg_index}), .cfg_data(cfg_data),
    .result(result)
  );

  // result: {count, err, pv, ev, npc}
  assign m_axis_tdata = {result[101:70], result[66:35], result[31:0]};
  assign m_axis_tuser = {result[69:67], result[34:32]};
endmodule
`default_nettype wire

// File: bench/mips_subset_execute_unit_core_tb.sv
// Self-checking bench for mips_subset_execute_unit_core: streams instruction beats,
// predicts every result beat in a small scoreboard class and compares them.
// Depends on msxu_pkg and the design top level.
module mips_subset_execute_unit_core_tb;
  import msxu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DBYTES = DATA_BYTES_DEF;
  localparam int WIN = 2048;        // program window kept in fetch range
  localparam int LIMIT = 600000;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [31:0] npc;
    logic [2:0]  ev;
    logic [31:0] pv;
    logic [2:0]  err;
    logic [31:0] cnt;
  } exec_res_t;

  class exec_scoreboard;
    logic [31:0] start_addr, pc, hi, lo, count;
    logic [24:0] words;
    logic [31:0] regs[32];
    logic [31:0] mem[int];
    logic [31:0] stored_addrs[$];
    bit halted, unsafe_read;
    exec_res_t expected_q[$];
    int errors, results;
    int ev_seen[8];

    function new();
      start_addr = START_RESET;
      pc = START_RESET;
      words = '0;
      foreach (regs[i]) regs[i] = '0;
      regs[28] = GP_RESET;
      regs[29] = DATA_BASE + DBYTES;
      hi = '0; lo = '0; count = '0; halted = 0;
      errors = 0; results = 0;
    endfunction

    function void config_write(logic [2:0] idx, logic [31:0] val);
      if (idx == CFG_START) begin
        start_addr = val;
        if (count == 0 && !halted) pc = val;
      end else if (idx == CFG_WORDS) begin
        words = val[24:0];
      end
    endfunction

    function exec_res_t run(logic [31:0] ins, logic [31:0] inval, bit commit);
      logic [5:0] op, fn;
      logic [4:0] rs, rt, rd, sh, wr;
      logic [31:0] uimm, simm, a, b, npc, wv, nhi, nlo, addr, off, cnt;
      logic [25:0] tg;
      logic signed [63:0] prod;
      int x, y;
      bit mw;
      exec_res_t r;
      r = '0;
      cnt = count + 1;
      r.cnt = cnt;
      unsafe_read = 0;
      if (((pc - TEXT_BASE) >> 2) >= {7'd0, words}) begin
        r.npc = pc; r.ev = EV_ERROR; r.err = ER_FETCH;
        if (commit) begin
          count = cnt; halted = 1;
        end
        return r;
      end
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
      sh = ins[10:6]; fn = ins[5:0]; tg = ins[25:0];
      uimm = {16'd0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      a = regs[rs]; b = regs[rt];
      npc = pc + 4; nhi = hi; nlo = lo; wr = '0; wv = '0; mw = 0; off = '0;
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL: begin wr = rd; wv = b << sh; end
            FN_SRA: begin wr = rd; wv = $signed(b) >>> sh; end
            FN_JR: npc = a;
            FN_MFHI: begin wr = rd; wv = hi; end
            FN_MFLO: begin wr = rd; wv = lo; end
            FN_MULT: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              nlo = prod[31:0]; nhi = prod[63:32];
            end
            FN_DIV: begin
              if (b == 0) begin
                r.ev = EV_ERROR; r.err = ER_DIVZERO;
              end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
                nlo = 32'h8000_0000; nhi = '0;
              end else begin
                x = $signed(a); y = $signed(b);
                nlo = x / y; nhi = x % y;
              end
            end
            FN_ADDU: begin wr = rd; wv = a + b; end
            FN_SUBU: begin wr = rd; wv = a - b; end
            FN_SLT: begin wr = rd; wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; end
            default: begin r.ev = EV_ERROR; r.err = ER_BADOP; end
          endcase
        end
        OP_J: npc = {npc[31:28], tg, 2'b00};
        OP_JAL: begin wr = 5'd31; wv = npc; npc = {npc[31:28], tg, 2'b00}; end
        OP_BEQ: if (a == b) npc = npc + (simm << 2);
        OP_BNE: if (a != b) npc = npc + (simm << 2);
        OP_ADDIU: begin wr = rt; wv = a + simm; end
        OP_ANDI: begin wr = rt; wv = a & uimm; end
        OP_LUI: begin wr = rt; wv = uimm << 16; end
        OP_TRAP: begin
          case (tg[3:0])
            TR_NEWLINE: r.ev = EV_NEWLINE;
            TR_PRINT: begin r.ev = EV_PRINT; r.pv = a; end
            TR_READ: begin r.ev = EV_READ; wr = rt; wv = inval; end
            TR_EXIT: r.ev = EV_EXIT;
            default: begin r.ev = EV_ERROR; r.err = ER_BADTRAP; end
          endcase
        end
        OP_LW, OP_SW: begin
          addr = a + simm;
          off = addr - DATA_BASE;
          if (addr[1:0] != 2'b00) begin
            r.ev = EV_ERROR; r.err = ER_UNALIGNED;
          end else if (off >= DBYTES) begin
            r.ev = EV_ERROR; r.err = ER_RANGE;
          end else if (op == OP_LW) begin
            wr = rt;
            if (mem.exists(off >> 2)) wv = mem[off >> 2];
            else unsafe_read = 1;
          end else begin
            mw = 1;
          end
        end
        default: begin r.ev = EV_ERROR; r.err = ER_BADOP; end
      endcase
      r.npc = npc;
      if (commit) begin
        if (wr != 0) regs[wr] = wv;
        hi = nhi; lo = nlo;
        if (mw) begin
          if (!mem.exists(off >> 2)) stored_addrs.push_back(off + DATA_BASE);
          mem[off >> 2] = b;
        end
        pc = npc; count = cnt;
        if (r.ev == EV_ERROR || r.ev == EV_EXIT) halted = 1;
      end
      return r;
    endfunction

    function void note_input(logic [31:0] ins, logic [31:0] inval);
      if (halted) return;
      expected_q.push_back(run(ins, inval, 1));
    endfunction

    function void check(exec_res_t got);
      exec_res_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: npc %h", got.npc);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      results++;
      ev_seen[got.ev]++;
      if (got.npc !== e.npc) begin
        $error("next_pc exp %h got %h", e.npc, got.npc); errors++;
      end
      if (got.ev !== e.ev) begin
        $error("event_res exp %0d got %0d", e.ev, got.ev); errors++;
      end
      if (got.pv !== e.pv) begin
        $error("print_value exp %h got %h", e.pv, got.pv); errors++;
      end
      if (got.err !== e.err) begin
        $error("error_code exp %0d got %0d", e.err, got.err); errors++;
      end
      if (got.cnt !== e.cnt) begin
        $error("executed_count exp %0d got %0d", e.cnt, got.cnt); errors++;
      end
    endfunction

    function bit in_window(logic [31:0] a);
      logic [31:0] idx;
      idx = (a - TEXT_BASE) >> 2;
      return idx < WIN && idx < {7'd0, words};
    endfunction

    // Random instruction that keeps the unit running inside the program window.
    function logic [31:0] gen_running(output logic [31:0] inval);
      logic [31:0] ins, addr, d;
      logic [5:0] fns[10];
      logic [4:0] rs, rt, rd;
      logic [15:0] imm;
      exec_res_t r;
      int k;
      fns = '{FN_SLL, FN_SRA, FN_JR, FN_MFHI, FN_MFLO, FN_MULT, FN_DIV, FN_ADDU,
              FN_SUBU, FN_SLT};
      for (int t = 0; t < 300; t++) begin
        inval = $urandom;
        rs = 5'($urandom); rt = 5'($urandom); rd = 5'($urandom);
        if (rd == 28 || rd == 29) rd = rd ^ 5'd2;
        imm = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 38) begin
          ins = {OP_SPECIAL, rs, rt, rd, 5'($urandom), fns[$urandom_range(0, 9)]};
        end else if (k < 52) begin
          if (rt == 28 || rt == 29) rt = rt ^ 5'd2;
          case ($urandom_range(0, 2))
            0: ins = {OP_ADDIU, rs, rt, imm};
            1: ins = {OP_ANDI, rs, rt, imm};
            default: ins = {OP_LUI, rs, rt, imm};
          endcase
        end else if (k < 62) begin
          if ($urandom_range(0, 3) != 0) rs = 5'd28 + 5'($urandom_range(0, 1));
          imm[1:0] = 2'b00;
          if (rs == 29) imm[15] = 1'b1;
          ins = {OP_SW, rs, rt, imm};
        end else if (k < 72 && stored_addrs.size() > 0) begin
          if (rt == 28 || rt == 29) rt = rt ^ 5'd2;
          addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
          if ($urandom_range(0, 2) != 0) rs = 5'd28 + 5'($urandom_range(0, 1));
          d = addr - regs[rs];
          ins = {OP_LW, rs, rt, d[15:0]};
        end else if (k < 82) begin
          imm = 16'($signed($urandom_range(0, 128)) - 64);
          ins = {($urandom_range(0, 1) ? OP_BEQ : OP_BNE), rs, rt, imm};
        end else if (k < 90) begin
          ins = {($urandom_range(0, 1) ? OP_J : OP_JAL),
                 26'((TEXT_BASE >> 2) + $urandom_range(0, WIN - 1))};
        end else begin
          if (rt == 28 || rt == 29) rt = rt ^ 5'd2;
          case ($urandom_range(0, 2))
            0: d = 32'(TR_NEWLINE);
            1: d = 32'(TR_PRINT);
            default: d = 32'(TR_READ);
          endcase
          ins = {OP_TRAP, rs, rt, 12'($urandom), d[3:0]};
        end
        r = run(ins, inval, 0);
        if (!unsafe_read && r.ev != EV_ERROR && r.ev != EV_EXIT && in_window(r.npc))
          return ins;
      end
      return {OP_J, 26'(TEXT_BASE >> 2)};
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [5:0] m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  exec_scoreboard sb = new();
  bit quiet = 0;
  bit pressure_done = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int items = 0;

  mips_subset_execute_unit_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("mips_subset_execute_unit_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check('{npc: m_axis_tdata[31:0], ev: m_axis_tuser[2:0], pv: m_axis_tdata[63:32],
                 err: m_axis_tuser[5:3], cnt: m_axis_tdata[95:64]});
  end

  // receiver: random stalls, one long hold-off to back the unit up
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 0;
    end else if (!pressure_done && sb.results >= 300) begin
      pressure_done <= 1;
      hold_cnt <= 400;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= quiet || $urandom_range(0, 99) >= 27;
    end
  end

  task automatic send_beat(logic [31:0] ins, logic [31:0] inval);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {inval, ins};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(ins, inval);
    items++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx[0:0];
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.config_write(idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  initial begin
    logic [31:0] ins, inval;
    int kind;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // late entry point writes, extremes first
    write_reg(CFG_WORDS, 32'd0);
    write_reg(CFG_START, 32'hffff_ffff);
    write_reg(CFG_START, 32'd0);
    write_reg(CFG_START, TEXT_BASE);
    write_reg(CFG_WORDS, 32'h0100_0000);

    send_beat(itype(OP_ADDIU, 0, 0, 16'd5), '0);
    send_beat(itype(OP_LUI, 0, 8, 16'hffff), '0);
    send_beat(itype(OP_ADDIU, 8, 8, 16'hffff), '0);
    send_beat(itype(OP_LUI, 0, 9, 16'h8000), '0);
    send_beat(itype(OP_ADDIU, 0, 10, 16'hffff), '0);
    send_beat(rtype(9, 10, 0, 0, FN_DIV), '0);
    send_beat(rtype(0, 0, 11, 0, FN_MFHI), '0);
    send_beat(rtype(0, 0, 12, 0, FN_MFLO), '0);
    send_beat(rtype(9, 9, 0, 0, FN_MULT), '0);
    send_beat(rtype(0, 0, 13, 0, FN_MFHI), '0);
    send_beat(rtype(0, 10, 14, 31, FN_SLL), '0);
    send_beat(rtype(0, 9, 15, 31, FN_SRA), '0);
    send_beat(rtype(9, 9, 16, 0, FN_ADDU), '0);
    send_beat(rtype(0, 10, 17, 0, FN_SUBU), '0);
    send_beat(rtype(9, 10, 18, 0, FN_SLT), '0);
    send_beat(itype(OP_ANDI, 10, 19, 16'hffff), '0);
    send_beat(itype(OP_SW, 28, 10, 16'h8000), '0);
    send_beat(itype(OP_LW, 28, 20, 16'h8000), '0);
    send_beat({OP_TRAP, 26'h3ff_fff0}, '1);
    send_beat(itype(OP_TRAP, 9, 0, 16'(TR_PRINT)), '0);
    send_beat(itype(OP_TRAP, 0, 21, 16'(TR_READ)), 32'h8000_0000);
    send_beat(itype(OP_TRAP, 0, 22, 16'(TR_READ)), 32'h7fff_ffff);
    send_beat(itype(OP_BEQ, 0, 0, 16'd1), '0);
    send_beat(itype(OP_BNE, 9, 0, 16'hfffe), '0);
    send_beat({OP_JAL, 26'((TEXT_BASE >> 2) + 64)}, '0);
    send_beat(rtype(31, 0, 0, 0, FN_JR), '0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_reg(CFG_WORDS, WIN);
        1: write_reg(CFG_WORDS, 32'h0100_0000);
        2: write_reg(CFG_WORDS, $urandom_range(WIN, 32'h00ff_ffff));
        default: write_reg(CFG_WORDS, WIN + $urandom_range(0, 100));
      endcase
      write_reg(CFG_START, $urandom);
      quiet = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ins = sb.gen_running(inval);
        send_beat(ins, inval);
      end
    end
    drain();
    quiet = 0;

    // one halting beat ends the program
    kind = $urandom_range(0, 6);
    inval = $urandom;
    case (kind)
      0: ins = rtype(5'($urandom), 0, 5'($urandom), 0, FN_DIV);
      1: ins = {6'h3f, 26'($urandom)};
      2: ins = {OP_TRAP, 22'($urandom), 4'h3};
      3: ins = itype(OP_LW, 28, 1, 16'h0001);
      4: ins = itype(OP_SW, 0, 1, 16'h0000);
      5: ins = {OP_TRAP, 22'($urandom), TR_EXIT};
      default: begin
        write_reg(CFG_WORDS, (sb.pc - TEXT_BASE) >> 2);
        ins = $urandom;
      end
    endcase
    send_beat(ins, inval);
    drain();

    $display("ran %0d instruction beats, %0d results checked, final halt kind %0d",
             items, sb.results, kind);
    $display("events: none %0d newline %0d print %0d read %0d exit %0d error %0d",
             sb.ev_seen[0], sb.ev_seen[1], sb.ev_seen[2], sb.ev_seen[3],
             sb.ev_seen[4], sb.ev_seen[5]);
    if (sb.errors == 0) begin
      $display("mips_subset_execute_unit_core test passed");
    end else begin
      $display("mips_subset_execute_unit_core test failed");
    end
    $finish;
  end
endmodule
